>>> src/assert_macros.svh
// Assertion macros for the RTL files of the identifier hash engine; used by xid_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define XID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define XID_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define XID_ASSERT(label, clk, rst_n, prop, msg)
`define XID_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> src/xid_pkg.sv
// Shared types and constants of the identifier hash engine.
package xid_pkg;

    // Default byte limit of the string hash.
    localparam int DATA_BYTES_DEF = 128;

    // Number of finished identifiers that may wait between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Half width of the 64-bit multiply, done as 32x32 partial products.
    localparam int HALF_W = 32;

    // Mixer multipliers and the combine offset.
    localparam logic [63:0] MIX_C1     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2     = 64'h94d049bb133111eb;
    localparam logic [63:0] COMBINE_K  = 64'h000000009e3779b9;

    // String hash fold: the nibble at bits 28 to 31 is moved down by 24.
    localparam logic [3:0]  FOLD_NIBBLE = 4'hf;
    localparam int          FOLD_POS    = 28;
    localparam int          FOLD_DROP   = 24;
    localparam logic [63:0] FOLD_MASK   = 64'(FOLD_NIBBLE) << FOLD_POS;

    // Mixer shift amounts.
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // Which value of the identifier is being mixed.
    localparam logic [1:0] SEL_BRANCH = 2'd0;
    localparam logic [1:0] SEL_GLOBAL = 2'd1;
    localparam logic [1:0] SEL_FORMAT = 2'd2;

    // Partial product phases of one 64-bit multiply.
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_HI_LO = 2'd2;

    // One finished identifier handed from the front to the back.
    typedef struct packed {
        logic [63:0] text_hash;
        logic [6:0]  branch_len;
        logic [6:0]  global_len;
        logic [31:0] format_code;
    } job_t;

endpackage

>>> src/xid_if.sv
// Valid/ready channel interfaces for identifier bytes and hash results.
interface xid_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [6:0]  global_len;
    logic [6:0]  branch_len;
    logic signed [31:0] format_code;

    modport source (output valid, data_byte, last_byte, global_len, branch_len,
                    format_code, input ready);
    modport sink   (input valid, data_byte, last_byte, global_len, branch_len,
                    format_code, output ready);
endinterface

interface xid_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

>>> src/xid_front.sv
// Front part: takes identifier bytes and runs the running string hash.
module xid_front #(
    parameter int DATA_BYTES = xid_pkg::DATA_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    xid_in_if.sink       item,
    output logic         push,
    output xid_pkg::job_t push_job,
    input  logic         q_full
);

    localparam logic [7:0] LIMIT = 8'(DATA_BYTES);

    logic [63:0] hash_reg, hash_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        skip;
    logic [63:0] shifted;
    logic [63:0] fold;
    logic [63:0] hashed;
    logic [63:0] hash_after;
    logic [7:0]  cnt_inc;

    // A beat is taken whenever the queue has room for a finished identifier.
    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    // One step of the string hash for the incoming byte.
    always_comb
    begin
        skip       = stopped_reg || (cnt_reg >= LIMIT) || (item.data_byte == 8'd0);
        shifted    = (hash_reg << 4) + {{56{item.data_byte[7]}}, item.data_byte};
        fold       = shifted & xid_pkg::FOLD_MASK;
        hashed     = shifted ^ (fold >> xid_pkg::FOLD_DROP) ^ fold;
        cnt_inc    = cnt_reg + 8'd1;
        hash_after = skip ? hash_reg : hashed;
    end

    // State update; the final byte hands the job on and clears the state.
    always_comb
    begin
        hash_next    = hash_reg;
        stopped_next = stopped_reg;
        cnt_next     = cnt_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                hash_next    = '0;
                stopped_next = 1'b0;
                cnt_next     = '0;
            end
            else if (skip)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                hash_next    = hashed;
                cnt_next     = cnt_inc;
                stopped_next = (cnt_inc >= LIMIT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg    <= '0;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            hash_reg    <= hash_next;
            stopped_reg <= stopped_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Job for the back part.
    assign push                 = accept && item.last_byte;
    assign push_job.text_hash   = hash_after;
    assign push_job.branch_len  = item.branch_len;
    assign push_job.global_len  = item.global_len;
    assign push_job.format_code = item.format_code;

endmodule

>>> src/xid_queue.sv
// Short queue of finished identifiers between the front and the back part.
module xid_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  xid_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output xid_pkg::job_t pop_job
);

    localparam int DEPTH = xid_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    xid_pkg::job_t    slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    // Pointer and fill count update; wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> src/xid_back.sv
// Back part: mixes the lengths and format id and combines them into the result.
`include "assert_macros.svh"

module xid_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  xid_pkg::job_t pop_job,
    output logic          pop,
    xid_out_if.source     result
);

    localparam int HW = xid_pkg::HALF_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PRE    = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_MID    = 8'b0000_1000,
        S_FIN    = 8'b0001_0000,
        S_COMB_A = 8'b0010_0000,
        S_COMB_B = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic        second_reg, second_next;
    logic [1:0]  sel_reg, sel_next;
    logic [63:0] s_reg, s_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] t_reg, t_next;
    logic [6:0]  glen_reg, glen_next;
    logic [31:0] fmt_reg, fmt_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    logic [63:0]   mul_c;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [63:0]   product;
    logic          slot_free;

    assign slot_free = !out_valid_reg || result.ready;

    // Shared 32x32 multiplier; operand halves picked by the phase.
    always_comb
    begin
        mul_c = second_reg ? xid_pkg::MIX_C2 : xid_pkg::MIX_C1;
        unique case (phase_reg)
            xid_pkg::PH_LO_LO:
            begin
                mul_a = x_reg[HW-1:0];
                mul_b = mul_c[HW-1:0];
            end
            xid_pkg::PH_LO_HI:
            begin
                mul_a = x_reg[HW-1:0];
                mul_b = mul_c[2*HW-1:HW];
            end
            xid_pkg::PH_HI_LO:
            begin
                mul_a = x_reg[2*HW-1:HW];
                mul_b = mul_c[HW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        product = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};
    end

    // Finalization sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        second_next    = second_reg;
        sel_next       = sel_reg;
        s_next         = s_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        t_next         = t_reg;
        glen_next      = glen_reg;
        fmt_next       = fmt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    // First combine starts from zero, so it is a plain add.
                    pop        = 1'b1;
                    s_next     = pop_job.text_hash + xid_pkg::COMBINE_K;
                    x_next     = {57'd0, pop_job.branch_len};
                    glen_next  = pop_job.global_len;
                    fmt_next   = pop_job.format_code;
                    sel_next   = xid_pkg::SEL_BRANCH;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                x_next      = x_reg ^ (x_reg >> xid_pkg::MIX_SH0);
                phase_next  = xid_pkg::PH_LO_LO;
                second_next = 1'b0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                // Low 64 bits of the product, one partial product per cycle.
                if (phase_reg == xid_pkg::PH_LO_LO)
                begin
                    acc_next = product;
                end
                else
                begin
                    acc_next = {acc_reg[2*HW-1:HW] + product[HW-1:0], acc_reg[HW-1:0]};
                end
                if (phase_reg == xid_pkg::PH_HI_LO)
                begin
                    state_next = second_reg ? S_FIN : S_MID;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            S_MID:
            begin
                x_next      = acc_reg ^ (acc_reg >> xid_pkg::MIX_SH1);
                phase_next  = xid_pkg::PH_LO_LO;
                second_next = 1'b1;
                state_next  = S_MUL;
            end
            S_FIN:
            begin
                x_next     = acc_reg ^ (acc_reg >> xid_pkg::MIX_SH2);
                state_next = S_COMB_A;
            end
            S_COMB_A:
            begin
                t_next     = (s_reg << 6) + (s_reg >> 2);
                x_next     = x_reg + xid_pkg::COMBINE_K;
                state_next = S_COMB_B;
            end
            S_COMB_B:
            begin
                s_next = s_reg ^ (x_reg + t_reg);
                if (sel_reg == xid_pkg::SEL_FORMAT)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    x_next     = (sel_reg == xid_pkg::SEL_BRANCH) ?
                                 {57'd0, glen_reg} : {{32{fmt_reg[31]}}, fmt_reg};
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_PRE;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = s_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= xid_pkg::PH_LO_LO;
            second_reg    <= 1'b0;
            sel_reg       <= xid_pkg::SEL_BRANCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            second_reg    <= second_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        t_reg        <= t_next;
        glen_reg     <= glen_next;
        fmt_reg      <= fmt_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.hash_value = out_data_reg;

    `XID_ASSERT(a_state_onehot, clk, rst_n, $onehot(state_reg), "sequencer state is not one-hot")
    `XID_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !q_valid, "job taken from an empty queue")
    `XID_ASSERT_NEVER(a_sel_range, clk, rst_n, sel_reg == 2'd3, "mix selector out of range")
    `XID_ASSERT(a_out_load, clk, rst_n, (state_reg == S_OUT) && slot_free |=> out_valid_reg, "finished result not presented")

endmodule

>>> src/xid_hash_engine_top.sv
// Top level of the identifier hash engine.
// Identifier bytes are taken one beat per cycle on item while the queue has
// room; the running string hash keeps pace with them. The beat that carries
// last_byte passes the string hash with the lengths and format id into a
// two-entry queue, and the byte side keeps running while the finalizer works.
// The finalizer uses one shared 32x32 multiplier and takes one job at a time:
// each of the three mixes runs an xor-shift, two 64-bit multiplies of three
// partial products each with an xor-shift after each, and the two-state
// combine (S_COMB_A, S_COMB_B). The result beat on result waits in its own
// register while the next job is finalized.
module xid_hash_engine_top #(
    parameter int DATA_BYTES = xid_pkg::DATA_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    xid_in_if.sink    item,
    xid_out_if.source result
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    xid_pkg::job_t push_job;
    xid_pkg::job_t pop_job;

    xid_front #(
        .DATA_BYTES (DATA_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    xid_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_job  (pop_job)
    );

    xid_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .pop_job (pop_job),
        .pop     (pop),
        .result  (result)
    );

endmodule
